/* design/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the periodic ripple corrector.
// ----------------------------------------------------------------------------
package prc_pkg;

    // input action codes
    localparam logic ACT_CORRECT = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_PHASE_DC = 2'd1;
    localparam logic [1:0] CFG_MAG_DC   = 2'd2;

    // divider and cosine pipeline depths
    localparam int DIV_BITS   = 24;
    localparam int COS_STAGES = 4;

    // odd polynomial constants for the sine, Q30
    localparam logic [30:0] COS_A = 31'd1686629713;
    localparam logic [29:0] COS_B = 30'd688904866;
    localparam logic [26:0] COS_C = 27'd76016977;

    // one table's segment, picked at classification time
    typedef struct packed {
        logic [31:0]        diff;
        logic [31:0]        den;
        logic signed [15:0] off_a;
        logic signed [15:0] off_b;
        logic signed [31:0] amp_a;
        logic signed [31:0] amp_b;
    } seg_t;

    // queue entry between front and back
    typedef struct packed {
        logic signed [15:0] phase;
        seg_t               ph;
        seg_t               mg;
    } qent_t;

    // configuration seen by the back end
    typedef struct packed {
        logic               enabled;
        logic signed [31:0] phase_dc;
        logic signed [31:0] mag_dc;
    } cfg_t;

endpackage

/* design/prc_if.sv */
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface prc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic               table_select;
    logic [2:0]         point_index;
    logic [31:0]        frequency_hz;
    logic signed [15:0] phase_angle;
    logic signed [15:0] point_offset;
    logic signed [31:0] point_amplitude;

    modport source (output valid, action, table_select, point_index, frequency_hz,
                    phase_angle, point_offset, point_amplitude, input ready);
    modport sink (input valid, action, table_select, point_index, frequency_hz,
                  phase_angle, point_offset, point_amplitude, output ready);
endinterface

interface prc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] corrected_phase;
    logic signed [31:0] mag_correction;

    modport source (output valid, corrected_phase, mag_correction, input ready);
    modport sink (input valid, corrected_phase, mag_correction, output ready);
endinterface

/* design/periodic_ripple_corrector.sv */
// ----------------------------------------------------------------------------
// periodic_ripple_corrector
// Coupler ripple correction of phase and magnitude readings.
// ----------------------------------------------------------------------------
// Request channel: a load transaction writes one breakpoint of the phase or
// magnitude table and gives no result; a correct transaction gives one result
// transaction with the corrected phase and the magnitude correction.
// Configuration: write cfg_we with cfg_index and cfg_data, only while idle.
// Throughput: one transaction per cycle unless a held result stalls it. The
// front end locates the segment in the breakpoint registers in the cycle of
// acceptance; the back end is a fully pipelined datapath (24-stage fraction
// divider, interpolation, 4-stage cosine, scaling, result register).
// Reset: clears the queue, the pipeline valids and the configuration
// (corrections disabled); breakpoints hold no value until loaded.
// Stall: a held result freezes the back end; the two-entry queue then fills
// and request ready drops until the result is taken.
// ----------------------------------------------------------------------------
module periodic_ripple_corrector
    import prc_pkg::*;
#(
    parameter int NUM_POINTS = 6
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    prc_in_if.sink      request,
    prc_out_if.source   result
);

    logic               enabled_reg;
    logic signed [31:0] phase_dc_reg;
    logic signed [31:0] mag_dc_reg;
    cfg_t               cfg;
    logic               q_push, q_full, q_valid, q_pop;
    qent_t              q_din, q_dout;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            phase_dc_reg <= '0;
            mag_dc_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:   enabled_reg  <= cfg_data[0];
                CFG_PHASE_DC: phase_dc_reg <= cfg_data;
                CFG_MAG_DC:   mag_dc_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg = '{enabled: enabled_reg, phase_dc: phase_dc_reg, mag_dc: mag_dc_reg};

    prc_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .clk     (clk),
        .request (request),
        .full    (q_full),
        .push    (q_push),
        .entry   (q_din)
    );

    prc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_dout)
    );

    prc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_dout),
        .q_pop   (q_pop),
        .result  (result)
    );

`ifndef SYNTH
    // load transactions never enter the arithmetic queue
    a_load_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.action == ACT_LOAD) |-> !q_push)
        else $error("load transaction pushed to queue");

    // bypass gives zero magnitude correction
    a_bypass_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !enabled_reg) |-> (result.mag_correction == 32'sd0))
        else $error("nonzero magnitude correction while disabled");

    // queue never overflows
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |=> !(q_push && $past(!q_pop || !q_valid)))
        else $error("queue written while full");
`endif

endmodule

/* design/prc_front.sv */
// ----------------------------------------------------------------------------
// prc_front
// Takes request transactions, writes breakpoints and locates segments.
// ----------------------------------------------------------------------------
module prc_front
    import prc_pkg::*;
#(
    parameter int NUM_POINTS = 6
)(
    input  logic        clk,
    prc_in_if.sink      request,
    input  logic        full,
    output logic        push,
    output qent_t       entry
);

    localparam int IW = $clog2(NUM_POINTS);
    localparam logic [4:0] NP_LIMIT = 5'(NUM_POINTS);

    logic [31:0]        freq_reg [2][NUM_POINTS];
    logic signed [15:0] off_reg  [2][NUM_POINTS];
    logic signed [31:0] amp_reg  [2][NUM_POINTS];
    seg_t               seg_c    [2];
    logic               accept;
    logic [IW-1:0]      wr_idx;

    assign request.ready = !full;
    assign accept = request.valid && request.ready;
    assign wr_idx = IW'(request.point_index);

    // breakpoint writes, out-of-range indexes dropped
    always_ff @(posedge clk)
    begin
        if (accept && request.action == ACT_LOAD && {2'b00, request.point_index} < NP_LIMIT)
        begin
            freq_reg[request.table_select][wr_idx] <= request.frequency_hz;
            off_reg[request.table_select][wr_idx]  <= request.point_offset;
            amp_reg[request.table_select][wr_idx]  <= request.point_amplitude;
        end
    end

    // segment search per table
    for (genvar t = 0; t < 2; t++)
    begin : g_loc
        always_comb
        begin
            logic [IW-1:0] k_sel;
            logic [IW-1:0] lo_idx;
            logic          hold;
            hold  = 1'b1;
            k_sel = IW'(NUM_POINTS - 1);
            for (int k = NUM_POINTS - 1; k >= 1; k--)
            begin
                if (request.frequency_hz < freq_reg[t][k])
                begin
                    hold  = 1'b0;
                    k_sel = IW'(k);
                end
            end
            if (request.frequency_hz < freq_reg[t][0])
            begin
                hold  = 1'b1;
                k_sel = '0;
            end
            lo_idx = hold ? k_sel : k_sel - 1'b1;
            seg_c[t].diff  = hold ? 32'd0 : request.frequency_hz - freq_reg[t][lo_idx];
            seg_c[t].den   = hold ? 32'd1 : freq_reg[t][k_sel] - freq_reg[t][lo_idx];
            seg_c[t].off_a = off_reg[t][lo_idx];
            seg_c[t].off_b = off_reg[t][k_sel];
            seg_c[t].amp_a = amp_reg[t][lo_idx];
            seg_c[t].amp_b = amp_reg[t][k_sel];
        end
    end

    // correct transactions go to the queue
    assign push        = accept && request.action == ACT_CORRECT;
    assign entry.phase = request.phase_angle;
    assign entry.ph    = seg_c[0];
    assign entry.mg    = seg_c[1];

endmodule

/* design/prc_queue.sv */
// ----------------------------------------------------------------------------
// prc_queue
// Two-entry queue between classification and arithmetic.
// ----------------------------------------------------------------------------
module prc_queue
    import prc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t din,
    input  logic  pop,
    output logic  full,
    output logic  valid,
    output qent_t dout
);

    qent_t      mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full   = count_reg == 2'd2;
    assign valid  = count_reg != 2'd0;
    assign dout   = mem_reg[rptr_reg];
    assign do_pop = pop && valid;

    // pointer and count update
    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

/* design/prc_div.sv */
// ----------------------------------------------------------------------------
// prc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prc_div
    import prc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         diff,
    input  logic [31:0]         den,
    output logic [DIV_BITS-1:0] quot
);

    logic [31:0]         r_reg [DIV_BITS];
    logic [31:0]         r_next [DIV_BITS];
    logic [31:0]         d_reg [DIV_BITS];
    logic [31:0]         d_next [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg [DIV_BITS];
    logic [DIV_BITS-1:0] q_next [DIV_BITS];

    // one compare and subtract per stage
    always_comb
    begin
        for (int i = 0; i < DIV_BITS; i++)
        begin
            logic [31:0]         rin;
            logic [DIV_BITS-1:0] qin;
            logic [32:0]         r2;
            logic                ge;
            rin = (i == 0) ? diff : r_reg[(i == 0) ? 0 : i - 1];
            qin = (i == 0) ? '0 : q_reg[(i == 0) ? 0 : i - 1];
            d_next[i] = (i == 0) ? den : d_reg[(i == 0) ? 0 : i - 1];
            r2 = {rin, 1'b0};
            ge = r2 >= {1'b0, d_next[i]};
            r_next[i] = ge ? 32'(r2 - {1'b0, d_next[i]}) : r2[31:0];
            q_next[i] = {qin[DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            d_reg <= d_next;
            q_reg <= q_next;
        end
    end

    assign quot = q_reg[DIV_BITS-1];

endmodule

/* design/prc_cos.sv */
// ----------------------------------------------------------------------------
// prc_cos
// Four-stage cosine of a binary angle, Q16 result.
// ----------------------------------------------------------------------------
module prc_cos
    import prc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [17:0] cos_q16
);

    logic [14:0] ua1_reg, ua2_reg, ua3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [30:0] x2_1_reg, x2_2_reg;
    logic [29:0] t1_reg;
    logic [30:0] t2_reg;
    logic signed [17:0] cos_reg;

    logic [14:0] ua_c;
    logic        neg_c;
    logic [30:0] x2_c;
    logic [29:0] t1_c;
    logic [30:0] t2_c;
    logic signed [17:0] cos_c;

    // fold the angle to a quarter turn around zero
    always_comb
    begin
        logic [15:0]        s;
        logic signed [17:0] u;
        logic [29:0]        sq;
        s = angle + 16'd16384;
        u = 18'($signed(s));
        if (u > 18'sd16384)
        begin
            u = 18'sd32768 - u;
        end
        else if (u < -18'sd16384)
        begin
            u = -18'sd32768 - u;
        end
        neg_c = u < 0;
        ua_c  = neg_c ? 15'(-u) : 15'(u);
        sq    = ua_c * ua_c;
        x2_c  = {sq, 1'b0} << 1;
    end

    // inner terms of the polynomial
    always_comb
    begin
        logic [57:0] p1;
        logic [60:0] p2;
        p1   = x2_1_reg * COS_C;
        t1_c = 30'(COS_B - 30'(p1[57:30]));
        p2   = x2_2_reg * t1_reg;
        t2_c = COS_A - p2[60:30];
    end

    // final product with rounding and sign
    always_comb
    begin
        logic [46:0] p3;
        logic [16:0] r;
        p3    = 47'(ua3_reg * t2_reg) + 47'd134217728;
        r     = p3[44:28];
        cos_c = neg3_reg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua1_reg  <= ua_c;
            neg1_reg <= neg_c;
            x2_1_reg <= x2_c;
            ua2_reg  <= ua1_reg;
            neg2_reg <= neg1_reg;
            x2_2_reg <= x2_1_reg;
            t1_reg   <= t1_c;
            ua3_reg  <= ua2_reg;
            neg3_reg <= neg2_reg;
            t2_reg   <= t2_c;
            cos_reg  <= cos_c;
        end
    end

    assign cos_q16 = cos_reg;

endmodule

/* design/prc_back.sv */
// ----------------------------------------------------------------------------
// prc_back
// Arithmetic pipeline: divide, interpolate, cosine, scale, result register.
// ----------------------------------------------------------------------------
module prc_back
    import prc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  qent_t     q_data,
    output logic      q_pop,
    prc_out_if.source result
);

    localparam int LAT = DIV_BITS + COS_STAGES + 2;

    typedef struct packed {
        logic signed [15:0] phase;
        logic signed [15:0] ph_off_a;
        logic signed [15:0] ph_off_b;
        logic signed [31:0] ph_amp_a;
        logic signed [31:0] ph_amp_b;
        logic signed [15:0] mg_off_a;
        logic signed [15:0] mg_off_b;
        logic signed [31:0] mg_amp_a;
        logic signed [31:0] mg_amp_b;
    } side_t;

    typedef struct packed {
        logic signed [15:0] phase;
        logic signed [31:0] ph_amp;
        logic signed [31:0] mg_amp;
    } carry_t;

    logic               adv;
    logic [LAT-1:0]     v_reg, v_next;
    side_t              side_reg [DIV_BITS];
    side_t              side_in;
    logic [DIV_BITS-1:0] ph_frac, mg_frac;
    carry_t             l_reg;
    logic signed [15:0] ph_off_l_reg, mg_off_l_reg;
    carry_t             c_reg [COS_STAGES];
    logic signed [17:0] ph_cos, mg_cos;
    logic signed [15:0] phase_m_reg;
    logic signed [31:0] pc_reg, mc_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_phase_reg, out_phase_next;
    logic signed [31:0] out_mag_reg, out_mag_next;

    // a + floor((b - a) * frac / 2^24)
    function automatic logic signed [15:0] lerp16(logic signed [15:0] a,
                                                  logic signed [15:0] b,
                                                  logic [23:0] frac);
        logic signed [16:0] dl;
        logic signed [41:0] p;
        logic signed [17:0] s;
        dl = 17'(b) - 17'(a);
        p  = dl * $signed({1'b0, frac});
        s  = 18'(p >>> 24);
        return a + s[15:0];
    endfunction

    function automatic logic signed [31:0] lerp32(logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  logic [23:0] frac);
        logic signed [32:0] dl;
        logic signed [57:0] p;
        logic signed [33:0] s;
        dl = 33'(b) - 33'(a);
        p  = dl * $signed({1'b0, frac});
        s  = 34'(p >>> 24);
        return a + s[31:0];
    endfunction

    // floor(amp * cos / 2^16) - dc, saturated
    function automatic logic signed [31:0] scale(logic signed [31:0] amp,
                                                 logic signed [17:0] cq,
                                                 logic signed [31:0] dc);
        logic signed [49:0] p;
        logic signed [34:0] s;
        p = amp * cq;
        s = 35'(p >>> 16) - 35'(dc);
        if (s > 35'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (s < -35'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // whole pipeline moves unless the result is held
    assign adv   = !out_valid_reg || result.ready;
    assign q_pop = adv;

    assign v_next = {v_reg[LAT-2:0], q_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= v_next;
            out_valid_reg <= v_reg[LAT-1];
        end
    end

    // fraction dividers, one per table
    prc_div u_div_ph (
        .clk  (clk),
        .en   (adv),
        .diff (q_data.ph.diff),
        .den  (q_data.ph.den),
        .quot (ph_frac)
    );

    prc_div u_div_mg (
        .clk  (clk),
        .en   (adv),
        .diff (q_data.mg.diff),
        .den  (q_data.mg.den),
        .quot (mg_frac)
    );

    assign side_in = '{phase:    q_data.phase,
                       ph_off_a: q_data.ph.off_a, ph_off_b: q_data.ph.off_b,
                       ph_amp_a: q_data.ph.amp_a, ph_amp_b: q_data.ph.amp_b,
                       mg_off_a: q_data.mg.off_a, mg_off_b: q_data.mg.off_b,
                       mg_amp_a: q_data.mg.amp_a, mg_amp_b: q_data.mg.amp_b};

    // result fields after the final stage
    always_comb
    begin
        logic signed [32:0] pcx;
        logic signed [16:0] step;
        pcx  = 33'(pc_reg) + 33'sd32768;
        step = 17'(pcx >>> 16);
        if (cfg.enabled)
        begin
            out_phase_next = phase_m_reg + step[15:0];
            out_mag_next   = mc_reg;
        end
        else
        begin
            out_phase_next = phase_m_reg;
            out_mag_next   = '0;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_BITS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            l_reg.phase  <= side_reg[DIV_BITS-1].phase;
            l_reg.ph_amp <= lerp32(side_reg[DIV_BITS-1].ph_amp_a,
                                   side_reg[DIV_BITS-1].ph_amp_b, ph_frac);
            l_reg.mg_amp <= lerp32(side_reg[DIV_BITS-1].mg_amp_a,
                                   side_reg[DIV_BITS-1].mg_amp_b, mg_frac);
            ph_off_l_reg <= lerp16(side_reg[DIV_BITS-1].ph_off_a,
                                   side_reg[DIV_BITS-1].ph_off_b, ph_frac);
            mg_off_l_reg <= lerp16(side_reg[DIV_BITS-1].mg_off_a,
                                   side_reg[DIV_BITS-1].mg_off_b, mg_frac);
            c_reg[0] <= l_reg;
            for (int i = 1; i < COS_STAGES; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end
            phase_m_reg   <= c_reg[COS_STAGES-1].phase;
            pc_reg        <= scale(c_reg[COS_STAGES-1].ph_amp, ph_cos, cfg.phase_dc);
            mc_reg        <= scale(c_reg[COS_STAGES-1].mg_amp, mg_cos, cfg.mag_dc);
            out_phase_reg <= out_phase_next;
            out_mag_reg   <= out_mag_next;
        end
    end

    // cosine of phase minus interpolated offset
    prc_cos u_cos_ph (
        .clk     (clk),
        .en      (adv),
        .angle   (16'(l_reg.phase - ph_off_l_reg)),
        .cos_q16 (ph_cos)
    );

    prc_cos u_cos_mg (
        .clk     (clk),
        .en      (adv),
        .angle   (16'(l_reg.phase - mg_off_l_reg)),
        .cos_q16 (mg_cos)
    );

    assign result.valid           = out_valid_reg;
    assign result.corrected_phase = out_phase_reg;
    assign result.mag_correction  = out_mag_reg;

endmodule

/* bench/periodic_ripple_corrector_tb.sv */
// ----------------------------------------------------------------------------
// periodic_ripple_corrector_tb
// Self-checking bench: loads breakpoint tables, sends correct transactions
// under several register settings and handshake gap patterns, and compares
// every result with an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module periodic_ripple_corrector_tb;
    import prc_pkg::*;

    localparam int NPTS      = 6;
    localparam int SETTLE    = 40;
    localparam int WD_LIMIT  = 5000;
    localparam int SEG_ITEMS = 425;

    // one request transaction
    typedef struct {
        bit        action;
        bit        tsel;
        bit [2:0]  idx;
        bit [31:0] freq;
        bit [15:0] phase;
        bit [15:0] off;
        bit [31:0] amp;
    } req_item_t;

    typedef struct {
        bit [15:0] phase;
        bit [31:0] mag;
    } corr_result_t;

    // ripple predictor and store of pending corrections
    class ripple_scoreboard;
        bit [31:0]      fq [2][NPTS];
        longint         offs [2][NPTS];
        longint         amps [2][NPTS];
        bit             enabled;
        longint         phase_dc;
        longint         mag_dc;
        corr_result_t   pending [$];
        int             errors;

        function void set_reg(bit [1:0] index, bit [31:0] data);
            if (index == CFG_ENABLE) enabled = data[0];
            else if (index == CFG_PHASE_DC) phase_dc = longint'($signed(data));
            else if (index == CFG_MAG_DC) mag_dc = longint'($signed(data));
        endfunction

        function longint cos16(bit [15:0] d);
            bit [15:0] s;
            longint    u, x2, t1, t2, r;
            bit        neg;
            s = d + 16'd16384;
            u = (s >= 16'd32768) ? longint'(s) - 65536 : longint'(s);
            if (u > 16384) u = 32768 - u;
            if (u < -16384) u = -32768 - u;
            neg = u < 0;
            if (neg) u = -u;
            x2 = u * u * 4;
            t1 = 64'sd688904866 - ((x2 * 64'sd76016977) >>> 30);
            t2 = 64'sd1686629713 - ((x2 * t1) >>> 30);
            r = (u * t2 + (64'sd1 << 27)) >>> 28;
            return neg ? -r : r;
        endfunction

        function longint interp(longint a, longint b, longint frac);
            return a + (((b - a) * frac) >>> 24);
        endfunction

        function longint table_corr(int t, longint phase, bit [31:0] f, longint dc);
            int                lo, hi;
            longint            frac, off, amp, v;
            longint unsigned   num, den;
            bit [15:0]         d;
            bit                found;
            lo = 0; hi = 0; frac = 0; found = 0;
            if (f >= fq[t][0])
            begin
                for (int k = 1; k < NPTS && !found; k++)
                begin
                    if (f < fq[t][k])
                    begin
                        num = longint'(f - fq[t][k-1]) << 24;
                        den = longint'(fq[t][k] - fq[t][k-1]);
                        frac = longint'(num / den);
                        lo = k - 1; hi = k; found = 1;
                    end
                end
                if (!found)
                begin
                    lo = NPTS - 1; hi = NPTS - 1;
                end
            end
            off = interp(offs[t][lo], offs[t][hi], frac);
            amp = interp(amps[t][lo], amps[t][hi], frac);
            d = 16'(phase - off);
            v = ((amp * cos16(d)) >>> 16) - dc;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v;
        endfunction

        function void note_request(req_item_t it);
            corr_result_t r;
            longint       ph, pc;
            if (it.action == ACT_LOAD)
            begin
                if (it.idx < NPTS)
                begin
                    fq[it.tsel][it.idx] = it.freq;
                    offs[it.tsel][it.idx] = longint'($signed(it.off));
                    amps[it.tsel][it.idx] = longint'($signed(it.amp));
                end
                return;
            end
            ph = longint'($signed(it.phase));
            if (enabled)
            begin
                pc = table_corr(0, ph, it.freq, phase_dc);
                r.phase = 16'(ph + ((pc + 32768) >>> 16));
                r.mag = 32'(table_corr(1, ph, it.freq, mag_dc));
            end
            else
            begin
                r.phase = it.phase;
                r.mag = '0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(bit [15:0] ph, bit [31:0] mag);
            corr_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction phase=%h mag=%h", ph, mag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ph !== e.phase)
            begin
                $error("corrected_phase expected %h actual %h", e.phase, ph);
                errors++;
            end
            if (mag !== e.mag)
            begin
                $error("mag_correction expected %h actual %h", e.mag, mag);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          tx_idle;
    int          rx_idle;
    int          quiet;

    prc_in_if  req ();
    prc_out_if res ();

    ripple_scoreboard sb;

    periodic_ripple_corrector #(.NUM_POINTS(NPTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req.sink),
        .result    (res.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: check accepted results, random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.corrected_phase, res.mag_correction);
        res.ready <= ($urandom_range(99) < rx_idle) ? 1'b0 : 1'b1;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(req_item_t it);
        while ($urandom_range(99) < tx_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.action          <= it.action;
        req.table_select    <= it.tsel;
        req.point_index     <= it.idx;
        req.frequency_hz    <= it.freq;
        req.phase_angle     <= it.phase;
        req.point_offset    <= it.off;
        req.point_amplitude <= it.amp;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] index, bit [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(index, data);
    endtask

    task automatic load_point(bit t, bit [2:0] i, bit [31:0] f, bit [15:0] o, bit [31:0] a);
        req_item_t it;
        it = '{ACT_LOAD, t, i, f, 16'($urandom), o, a};
        send(it);
    endtask

    task automatic correct(bit [31:0] f, bit [15:0] p);
        req_item_t it;
        it = '{ACT_CORRECT, 1'($urandom), 3'($urandom), f, p, 16'($urandom), $urandom};
        send(it);
    endtask

    function automatic bit [31:0] rand_amp();
        if ($urandom_range(1)) return $urandom;
        return 32'($signed($urandom_range(2097152)) - 1048576);
    endfunction

    // ascending table with random content
    task automatic load_table(bit t);
        bit [31:0] f;
        bit        tight;
        tight = ($urandom_range(9) == 0);
        f = $urandom_range(1000000);
        for (int i = 0; i < NPTS; i++)
        begin
            load_point(t, 3'(i), f, 16'($urandom), rand_amp());
            f = f + (tight ? $urandom_range(1, 10) : $urandom_range(1, 700000000));
        end
    endtask

    function automatic bit [31:0] pick_freq();
        int t, k;
        t = $urandom_range(1);
        k = $urandom_range(NPTS - 1);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return sb.fq[t][k] + 32'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    task automatic random_segment(int n);
        req_item_t it;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0: load_table(1'($urandom));
                1, 2:
                begin
                    it = '{ACT_LOAD, 1'($urandom), 3'($urandom), $urandom, 16'($urandom),
                           16'($urandom), rand_amp()};
                    it.phase = 16'($urandom);
                    send(it);
                end
                default: correct(pick_freq(), 16'($urandom));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        tx_idle = 0;
        rx_idle = 0;
        quiet = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.action = ACT_CORRECT;
        req.table_select = 1'b0;
        req.point_index = '0;
        req.frequency_hz = '0;
        req.phase_angle = '0;
        req.point_offset = '0;
        req.point_amplitude = '0;
        res.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled bypass before any table is loaded
        correct(32'd12345, 16'h7FFF);
        correct(32'hFFFF_FFFF, 16'h8000);

        // tables with extreme breakpoint content
        load_point(1'b0, 3'd0, 32'd0, 16'h7FFF, 32'h7FFF_FFFF);
        load_point(1'b0, 3'd1, 32'd1000, 16'h8000, 32'h8000_0000);
        load_point(1'b0, 3'd2, 32'd5000, 16'h0000, 32'h0001_0000);
        load_point(1'b0, 3'd3, 32'd90000, 16'h4000, 32'hFFF0_0000);
        load_point(1'b0, 3'd4, 32'd100000, 16'hC000, 32'h0000_0000);
        load_point(1'b0, 3'd5, 32'hFFFF_FFFF, 16'h1234, 32'h0200_0000);
        load_point(1'b1, 3'd0, 32'd100, 16'h8000, 32'h8000_0000);
        load_point(1'b1, 3'd1, 32'd200, 16'h7FFF, 32'h7FFF_FFFF);
        load_point(1'b1, 3'd2, 32'd300, 16'h0000, 32'h0000_8000);
        load_point(1'b1, 3'd3, 32'd301, 16'h2000, 32'hFFFF_0000);
        load_point(1'b1, 3'd4, 32'd7000000, 16'hE000, 32'h0100_0000);
        load_point(1'b1, 3'd5, 32'hF000_0000, 16'h5555, 32'h0000_0001);
        // out of range indexes are ignored
        load_point(1'b1, 3'd6, 32'd50, 16'h1111, 32'h7FFF_FFFF);
        load_point(1'b0, 3'd7, 32'd50, 16'h2222, 32'h8000_0000);
        drain();

        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_PHASE_DC, 32'h0000_4000);
        write_reg(CFG_MAG_DC, 32'hFFFF_8000);
        write_reg(2'd3, 32'hDEAD_BEEF);
        // below first point, on points, inside segments, above last point
        correct(32'd0, 16'h0000);
        correct(32'd50, 16'h7FFF);
        correct(32'd500, 16'h8000);
        correct(32'd300, 16'h4000);
        correct(32'd95000, 16'hC000);
        correct(32'hF800_0000, 16'h1234);
        correct(32'hFFFF_FFFF, 16'hFFFF);
        drain();

        // saturating dc offsets
        write_reg(CFG_PHASE_DC, 32'h8000_0000);
        write_reg(CFG_MAG_DC, 32'h7FFF_FFFF);
        correct(32'd0, 16'h0000);
        correct(32'd700, 16'h8000);
        drain();

        load_table(1'b0);
        load_table(1'b1);
        drain();
        write_reg(CFG_PHASE_DC, $urandom);
        write_reg(CFG_MAG_DC, 32'($signed($urandom_range(131072)) - 65536));
        tx_idle = 24;
        rx_idle = 49;
        random_segment(SEG_ITEMS);
        drain();

        write_reg(CFG_PHASE_DC, 32'h7FFF_FFFF);
        write_reg(CFG_MAG_DC, 32'h8000_0000);
        tx_idle = 49;
        rx_idle = 24;
        random_segment(SEG_ITEMS);
        drain();

        write_reg(CFG_PHASE_DC, 32'd0);
        write_reg(CFG_MAG_DC, $urandom);
        tx_idle = 0;
        rx_idle = 0;
        random_segment(SEG_ITEMS);
        drain();

        write_reg(CFG_ENABLE, 32'd0);
        random_segment(SEG_ITEMS / 2);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        random_segment(SEG_ITEMS / 2);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
